>>> design/ring_queue_overwrite_with_mean_assert.svh
// assertion macros used by the checker module rqo_check
`ifndef RING_QUEUE_OVERWRITE_WITH_MEAN_ASSERT_SVH
`define RING_QUEUE_OVERWRITE_WITH_MEAN_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RQO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RQO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rqo_pkg.sv
`default_nettype none

package rqo_pkg;

    localparam int TAG_W       = 11;
    localparam int YEAR_W      = 14;
    localparam int CNT_W       = 4;
    localparam int CAP_W       = 4;
    localparam int KIND_W      = 2;
    localparam int ENTRY_W     = TAG_W + YEAR_W;
    // up to fifteen years of 14 bits
    localparam int SUM_W       = YEAR_W + CNT_W;
    localparam int RECIP_SHIFT = SUM_W + CNT_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MEAN
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [YEAR_W-1:0] year;
        logic [CNT_W-1:0]  count;
    } result_t;

    // ceil(2^RECIP_SHIFT / count), exact floor division for any sum below 2^SUM_W
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            4'd1:    r = 23'd4194304;
            4'd2:    r = 23'd2097152;
            4'd3:    r = 23'd1398102;
            4'd4:    r = 23'd1048576;
            4'd5:    r = 23'd838861;
            4'd6:    r = 23'd699051;
            4'd7:    r = 23'd599187;
            4'd8:    r = 23'd524288;
            4'd9:    r = 23'd466034;
            4'd10:   r = 23'd419431;
            4'd11:   r = 23'd381301;
            4'd12:   r = 23'd349526;
            4'd13:   r = 23'd322639;
            4'd14:   r = 23'd299594;
            4'd15:   r = 23'd279621;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/ring_queue_overwrite_with_mean.sv
// Ring queue of (item number, year) entries with overwrite of the oldest entry.
// An insert passes through accept with ring read, update and mean multiply, a
// remove through accept with ring read and update; the ring memory's registered
// read port and the reciprocal multiplier that forms the mean set these steps.
// One result word is returned per request; the next request is accepted while
// the previous result still waits on the master side. Writing the capacity
// register empties the queue; capacity 0 acts as 1 and values above
// MAX_ENTRIES act as MAX_ENTRIES. No clearing pass runs after reset.
`default_nettype none

module ring_queue_overwrite_with_mean #(
    parameter int MAX_ENTRIES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,   // capacity_in_use
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,     // item_tag[10:0], year_value[24:11]
    input  wire logic        s_tuser,     // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,     // removed_tag[10:0], removed_year[24:11],
                                          // mean_year[38:25], held_count[42:39]
    output logic      [1:0]  m_tuser      // result_kind
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    localparam int TAG_W   = rqo_pkg::TAG_W;
    localparam int YEAR_W  = rqo_pkg::YEAR_W;
    localparam int CNT_W   = rqo_pkg::CNT_W;
    localparam int SUM_W   = rqo_pkg::SUM_W;
    localparam int ENTRY_W = rqo_pkg::ENTRY_W;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
        if (int'(idx) + 1 >= int'(cap)) begin
            return '0;
        end
        return IDX_W'(int'(idx) + 1);
    endfunction

    rqo_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [rqo_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] eff_cap;

    logic              req_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [YEAR_W-1:0] year_reg;

    rqo_pkg::result_t res_reg, res_next;
    logic             res_valid_reg, res_valid_next;

    logic              m_valid_reg, m_valid_next;
    logic [47:0]       m_data_reg, m_data_next;
    logic [1:0]        m_kind_reg, m_kind_next;

    logic               accept;
    logic               out_free;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [TAG_W-1:0]   rd_tag;
    logic [YEAR_W-1:0]  rd_year;
    logic               drop;
    logic               mean_en;
    logic [YEAR_W-1:0]  mean_q;
    logic [YEAR_W-1:0]  out_mean;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == rqo_pkg::ST_IDLE) && (!res_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;

    assign rd_tag  = ram_rdata[TAG_W-1:0];
    assign rd_year = ram_rdata[ENTRY_W-1:TAG_W];
    assign drop    = count_reg >= eff_cap;
    assign mean_en = state_reg == rqo_pkg::ST_MEAN;
    assign ram_we  = (state_reg == rqo_pkg::ST_EXEC) && (req_reg == rqo_pkg::REQ_INSERT);

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(cap_reg) > MAX_ENTRIES) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_reg;
        end
    end

    rqo_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata({year_reg, tag_reg}),
        .re   (accept),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    rqo_mean u_mean (
        .aclk (aclk),
        .en   (mean_en),
        .sum  (sum_reg),
        .count(count_reg),
        .mean (mean_q)
    );

    assign out_mean = (res_reg.kind == rqo_pkg::KIND_INSERT) ? mean_q : '0;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_kind_next    = m_kind_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rqo_pkg::ST_IDLE: begin
                if (res_valid_reg && out_free) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = res_reg.kind;
                    m_data_next    = {5'd0, res_reg.count, out_mean, res_reg.year, res_reg.tag};
                    res_valid_next = 1'b0;
                end
                if (accept) begin
                    state_next = rqo_pkg::ST_EXEC;
                end
            end
            rqo_pkg::ST_EXEC: begin
                res_valid_next = 1'b1;
                res_next.tag   = '0;
                res_next.year  = '0;
                if (req_reg == rqo_pkg::REQ_INSERT) begin
                    // the oldest entry leaves silently when the ring is full
                    if (drop) begin
                        head_next  = advance(head_reg, eff_cap);
                        sum_next   = sum_reg - SUM_W'(rd_year) + SUM_W'(year_reg);
                        count_next = count_reg;
                    end else begin
                        sum_next   = sum_reg + SUM_W'(year_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    tail_next      = advance(tail_reg, eff_cap);
                    res_next.kind  = rqo_pkg::KIND_INSERT;
                    res_next.count = count_next;
                    state_next     = rqo_pkg::ST_MEAN;
                end else if (count_reg == '0) begin
                    res_next.kind  = rqo_pkg::KIND_EMPTY;
                    res_next.count = '0;
                    state_next     = rqo_pkg::ST_IDLE;
                end else begin
                    head_next      = advance(head_reg, eff_cap);
                    sum_next       = sum_reg - SUM_W'(rd_year);
                    count_next     = count_reg - CNT_W'(1);
                    res_next.kind  = rqo_pkg::KIND_REMOVED;
                    res_next.tag   = rd_tag;
                    res_next.year  = rd_year;
                    res_next.count = count_next;
                    state_next     = rqo_pkg::ST_IDLE;
                end
            end
            rqo_pkg::ST_MEAN: begin
                state_next = rqo_pkg::ST_IDLE;
            end
            default: begin
                state_next = rqo_pkg::ST_IDLE;
            end
        endcase

        // capacity write empties the queue
        if (cfg_we) begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rqo_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            cap_reg       <= rqo_pkg::CAP_RESET;
            res_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
        if (accept) begin
            req_reg  <= s_tuser;
            tag_reg  <= s_tdata[TAG_W-1:0];
            year_reg <= s_tdata[ENTRY_W-1:TAG_W];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

endmodule

`default_nettype wire

>>> design/rqo_ram.sv
`default_nettype none

module rqo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/rqo_mean.sv
`default_nettype none

// mean = sum / count as a multiply by a tabled reciprocal, result registered
module rqo_mean (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [rqo_pkg::SUM_W-1:0]  sum,
    input  wire logic [rqo_pkg::CNT_W-1:0]  count,
    output logic      [rqo_pkg::YEAR_W-1:0] mean
);

    localparam int PROD_W = rqo_pkg::SUM_W + rqo_pkg::RECIP_W;

    logic [rqo_pkg::RECIP_W-1:0] recip;
    logic [PROD_W-1:0]           prod;
    logic [rqo_pkg::YEAR_W-1:0]  mean_reg;

    assign recip = rqo_pkg::recip_of(count);
    assign prod  = PROD_W'(sum) * PROD_W'(recip);

    always_ff @(posedge aclk) begin
        if (en) begin
            mean_reg <= prod[rqo_pkg::RECIP_SHIFT +: rqo_pkg::YEAR_W];
        end
    end

    assign mean = mean_reg;

endmodule

`default_nettype wire

>>> design/rqo_check.sv
`default_nettype none

`include "ring_queue_overwrite_with_mean_assert.svh"

module rqo_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled result word holds
    `RQO_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // the block works on one request at a time
    `RQO_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request accepted right after another")

    // only an insert reports a mean
    `RQO_ASSERT_NOW(a_mean_on_insert, m_tvalid && m_tuser != rqo_pkg::KIND_INSERT, m_tdata[38:25] == 14'd0, "mean reported outside an insert")

    // an insert always leaves at least one entry
    `RQO_ASSERT_NOW(a_insert_count, m_tvalid && m_tuser == rqo_pkg::KIND_INSERT, m_tdata[42:39] != 4'd0, "insert reported an empty queue")

    // remove on empty reports nothing held and no entry
    `RQO_ASSERT_NOW(a_empty_word, m_tvalid && m_tuser == rqo_pkg::KIND_EMPTY, m_tdata[42:0] == 43'd0, "empty remove carried data")

endmodule

bind ring_queue_overwrite_with_mean rqo_check u_rqo_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

`default_nettype wire
